// ===== rtl/dpri_pkg.sv =====
package dpri_pkg;

	// coordinate and difference widths
	localparam int COORD_W   = 32;
	localparam int IN_FIELDS = 10;
	localparam int DIFF_W    = COORD_W + 1;

	// unit direction, Q.28
	localparam int UNIT_SHIFT = 28;
	localparam int NRM_W      = 30;
	localparam int DIR_W      = 30;
	localparam int SQ_W       = 2 * NRM_W + 1;
	localparam int ROOT_W     = NRM_W + 1;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int QD_W       = NRM_W + UNIT_SHIFT + 1;
	localparam int QU_STEPS   = UNIT_SHIFT + 1;
	localparam int UNIT_LAT   = 3 + ROOT_STEPS + 1 + QU_STEPS + 1;

	// rounding shift
	localparam int RND_IN_W  = 66;
	localparam int RND_OUT_W = RND_IN_W - UNIT_SHIFT;

	// rotation and line intersection widths
	localparam int CS_W  = 31;
	localparam int E_W   = 35;
	localparam int G_W   = RND_OUT_W;
	localparam int P_W   = E_W + DIFF_W + 2;
	localparam int DEN_W = P_W;
	localparam int NUM_W = P_W + G_W;

	// numerator products: one limb of the numerator per stage
	localparam int MUL_LIMB  = 19;
	localparam int MUL_STEPS = 4;

	// final division: quotient bits kept before forced saturation
	localparam int QB      = COORD_W + 2;
	localparam int DIV_LAT = QB + 2;

	localparam int MID_LAT   = 6 + MUL_STEPS;
	localparam int TOTAL_LAT = 1 + UNIT_LAT + MID_LAT + DIV_LAT;

	// shift right by the unit shift, rounding half away from zero
	function automatic logic signed [RND_OUT_W-1:0] rnd_q28(input logic signed [RND_IN_W-1:0] x);
		logic [RND_IN_W-1:0] mag;
		logic [RND_IN_W-1:0] m;
		mag = x[RND_IN_W-1] ? RND_IN_W'(-x) : RND_IN_W'(x);
		m = (mag + (RND_IN_W'(1) << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
		return x[RND_IN_W-1] ? -$signed(RND_OUT_W'(m)) : $signed(RND_OUT_W'(m));
	endfunction

endpackage

// ===== rtl/dpri_unit.sv =====
module dpri_unit import dpri_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [DIFF_W-1:0] vec_x,
	input  logic signed [DIFF_W-1:0] vec_y,
	output logic signed [DIR_W-1:0]  dir_x,
	output logic signed [DIR_W-1:0]  dir_y
);

	typedef struct packed {
		logic [NRM_W-1:0] nx;
		logic [NRM_W-1:0] ny;
		logic             sx;
		logic             sy;
		logic             zero;
	} uside_t;

	localparam int TOP = NRM_W - 1;
	localparam logic signed [DIR_W-1:0] ONE = DIR_W'(1) << UNIT_SHIFT;

	// stage 1: magnitudes and signs
	logic [DIFF_W-1:0] ax_s1, ay_s1;
	logic              sx_s1, sy_s1, zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= vec_x[DIFF_W-1] ? DIFF_W'(-vec_x) : DIFF_W'(vec_x);
			ay_s1   <= vec_y[DIFF_W-1] ? DIFF_W'(-vec_y) : DIFF_W'(vec_y);
			sx_s1   <= vec_x[DIFF_W-1];
			sy_s1   <= vec_y[DIFF_W-1];
			zero_s1 <= (vec_x == '0) && (vec_y == '0);
		end
	end

	// stage 2: leading one of the larger magnitude, scale into [2^29, 2^30)
	logic [DIFF_W-1:0] mx;
	logic [5:0]        msb;
	logic [NRM_W-1:0]  nx, ny;
	uside_t            side_s2;

	always_comb begin
		mx  = (ax_s1 > ay_s1) ? ax_s1 : ay_s1;
		msb = '0;
		for (int i = 0; i < DIFF_W; i++) begin
			if (mx[i]) msb = 6'(i);
		end
		if (msb > 6'(TOP)) begin
			nx = NRM_W'(ax_s1 >> (msb - 6'(TOP)));
			ny = NRM_W'(ay_s1 >> (msb - 6'(TOP)));
		end else begin
			nx = NRM_W'({{TOP{1'b0}}, ax_s1} << (6'(TOP) - msb));
			ny = NRM_W'({{TOP{1'b0}}, ay_s1} << (6'(TOP) - msb));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= '{nx: nx, ny: ny, sx: sx_s1, sy: sy_s1, zero: zero_s1};
		end
	end

	// stage 3: squared length
	logic [2*NRM_W-1:0]  pxx, pyy;
	logic [SQ_W-1:0]     rt_n_s [0:ROOT_STEPS];
	logic [SQ_W-1:0]     rt_r_s [0:ROOT_STEPS];
	uside_t              rt_side_s [0:ROOT_STEPS];

	assign pxx = side_s2.nx * side_s2.nx;
	assign pyy = side_s2.ny * side_s2.ny;

	always_ff @(posedge clk) begin
		if (en) begin
			rt_n_s[0]    <= SQ_W'(pxx) + SQ_W'(pyy);
			rt_r_s[0]    <= '0;
			rt_side_s[0] <= side_s2;
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * k);
		logic [SQ_W:0] trial;

		assign trial = {1'b0, rt_r_s[k]} + {1'b0, BIT};

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rt_n_s[k]} >= trial) begin
					rt_n_s[k+1] <= rt_n_s[k] - SQ_W'(trial);
					rt_r_s[k+1] <= (rt_r_s[k] >> 1) + BIT;
				end else begin
					rt_n_s[k+1] <= rt_n_s[k];
					rt_r_s[k+1] <= rt_r_s[k] >> 1;
				end
				rt_side_s[k+1] <= rt_side_s[k];
			end
		end
	end

	// divider set-up: component * 2^28 plus half the length
	logic [ROOT_W-1:0] root;
	logic [QD_W-1:0]   qx_r_s [0:QU_STEPS];
	logic [QD_W-1:0]   qy_r_s [0:QU_STEPS];
	logic [QU_STEPS-1:0] qx_q_s [0:QU_STEPS];
	logic [QU_STEPS-1:0] qy_q_s [0:QU_STEPS];
	logic [ROOT_W-1:0] qd_s [0:QU_STEPS];
	uside_t            qside_s [0:QU_STEPS];

	assign root = rt_r_s[ROOT_STEPS][ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			qx_r_s[0]  <= (QD_W'(rt_side_s[ROOT_STEPS].nx) << UNIT_SHIFT) + QD_W'(root >> 1);
			qy_r_s[0]  <= (QD_W'(rt_side_s[ROOT_STEPS].ny) << UNIT_SHIFT) + QD_W'(root >> 1);
			qx_q_s[0]  <= '0;
			qy_q_s[0]  <= '0;
			qd_s[0]    <= root;
			qside_s[0] <= rt_side_s[ROOT_STEPS];
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QU_STEPS; k++) begin : g_quo
		localparam int SH = QU_STEPS - 1 - k;
		logic [QD_W-1:0] dsh;

		assign dsh = QD_W'(qd_s[k]) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (qx_r_s[k] >= dsh) begin
					qx_r_s[k+1] <= qx_r_s[k] - dsh;
					qx_q_s[k+1] <= qx_q_s[k] | (QU_STEPS'(1) << SH);
				end else begin
					qx_r_s[k+1] <= qx_r_s[k];
					qx_q_s[k+1] <= qx_q_s[k];
				end
				if (qy_r_s[k] >= dsh) begin
					qy_r_s[k+1] <= qy_r_s[k] - dsh;
					qy_q_s[k+1] <= qy_q_s[k] | (QU_STEPS'(1) << SH);
				end else begin
					qy_r_s[k+1] <= qy_r_s[k];
					qy_q_s[k+1] <= qy_q_s[k];
				end
				qd_s[k+1]    <= qd_s[k];
				qside_s[k+1] <= qside_s[k];
			end
		end
	end

	// signs back on; a zero vector points along x
	logic signed [DIR_W-1:0] qx_sg, qy_sg;

	assign qx_sg = $signed({1'b0, qx_q_s[QU_STEPS]});
	assign qy_sg = $signed({1'b0, qy_q_s[QU_STEPS]});

	always_ff @(posedge clk) begin
		if (en) begin
			if (qside_s[QU_STEPS].zero) begin
				dir_x <= ONE;
				dir_y <= '0;
			end else begin
				dir_x <= qside_s[QU_STEPS].sx ? -qx_sg : qx_sg;
				dir_y <= qside_s[QU_STEPS].sy ? -qy_sg : qy_sg;
			end
		end
	end

endmodule

// ===== rtl/dpri_div.sv =====
module dpri_div import dpri_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic [NUM_W-1:0]          num_mag,
	input  logic                      num_neg,
	input  logic [DEN_W-1:0]          den_mag,
	input  logic signed [COORD_W-1:0] base,
	input  logic                      par,
	output logic signed [COORD_W-1:0] res
);

	typedef struct packed {
		logic [DEN_W-1:0]          den;
		logic                      neg;
		logic signed [COORD_W-1:0] base;
		logic                      par;
		logic                      ovf;
	} dside_t;

	localparam int SUM_W = QB + 3;
	localparam logic signed [SUM_W-1:0] HI = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] LO = SUM_W'(-(64'sd1 <<< (COORD_W - 1)));

	logic [NUM_W-1:0] r_s [0:QB];
	logic [QB-1:0]    q_s [0:QB];
	dside_t           sd_s [0:QB];

	// first stage: quotients past the kept range saturate anyway
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]  <= num_mag;
			q_s[0]  <= '0;
			sd_s[0] <= '{den: den_mag, neg: num_neg, base: base, par: par,
				ovf: num_mag >= (NUM_W'(den_mag) << QB)};
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int SH = QB - 1 - k;
		logic [NUM_W-1:0] dsh;

		assign dsh = NUM_W'(sd_s[k].den) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (r_s[k] >= dsh) begin
					r_s[k+1] <= r_s[k] - dsh;
					q_s[k+1] <= q_s[k] | (QB'(1) << SH);
				end else begin
					r_s[k+1] <= r_s[k];
					q_s[k+1] <= q_s[k];
				end
				sd_s[k+1] <= sd_s[k];
			end
		end
	end

	// round half up, apply sign, add centre, saturate; zero when lines are parallel
	logic                    rnd;
	logic [QB:0]             qm;
	logic signed [SUM_W-1:0] qs, sum;

	always_comb begin
		rnd = {r_s[QB], 1'b0} >= (NUM_W + 1)'(sd_s[QB].den);
		qm  = sd_s[QB].ovf ? ((QB + 1)'(1) << QB) : ((QB + 1)'(q_s[QB]) + (QB + 1)'(rnd));
		qs  = $signed(SUM_W'(qm));
		sum = SUM_W'(sd_s[QB].base) + (sd_s[QB].neg ? -qs : qs);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd_s[QB].par) begin
				res <= '0;
			end else if (sum > HI) begin
				res <= COORD_W'(HI);
			end else if (sum < LO) begin
				res <= COORD_W'(LO);
			end else begin
				res <= COORD_W'(sum);
			end
		end
	end

endmodule

// ===== rtl/dart_point_rotate_intersect_core.sv =====
// Dart point rotate-and-intersect core.
// Input channel s_axis_*: one transaction carries the five points A, B, D1,
// D2 (apex) and D3 as signed Q16.16 coordinates. Output channel m_axis_*:
// one transaction per input with P1 and P2 (saturated Q16.16) in tdata and
// the parallel-lines flag in tuser; both points are zero when it is set.
// The core is a fixed pipeline of 112 register stages; a new transaction is
// taken every cycle while the output is not stalled.
// The latency is set by the square root (31 stages) and divider (29 stages)
// of the unit-direction units, the four-stage numerator multiply and the
// 36-stage final divider.
// The whole pipeline advances together; when the receiver holds tready low
// with a result waiting, s_axis_tready drops and every stage holds, so
// nothing is lost or repeated. Reset clears the stage valid bits only; no
// state survives between items.
module dart_point_rotate_intersect_core import dpri_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// base_a_x, base_a_y, base_b_x, base_b_y, leg_one_x, leg_one_y,
	// apex_x, apex_y, leg_three_x, leg_three_y
	input  logic [319:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// first_out_x, first_out_y, second_out_x, second_out_y
	output logic [127:0] m_axis_tdata,
	// lines_parallel
	output logic         m_axis_tuser
);

	typedef struct packed {
		logic signed [DIFF_W-1:0]  vx;
		logic signed [DIFF_W-1:0]  vy;
		logic signed [DIFF_W-1:0]  wx;
		logic signed [DIFF_W-1:0]  wy;
		logic signed [DIFF_W-1:0]  fx;
		logic signed [DIFF_W-1:0]  fy;
		logic signed [COORD_W-1:0] d2x;
		logic signed [COORD_W-1:0] d2y;
	} side_t;

	typedef struct packed {
		logic [3:0]                neg;
		logic [DEN_W-1:0]          den;
		logic                      par;
		logic signed [COORD_W-1:0] d2x;
		logic signed [COORD_W-1:0] d2y;
	} mctl_t;

	logic                      en;
	logic [TOTAL_LAT-1:0]      vld_q;
	logic signed [COORD_W-1:0] fld [0:IN_FIELDS-1];

	// global advance: move when the output slot is free or being taken
	assign en            = !vld_q[TOTAL_LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], s_axis_tvalid};
		end
	end

	for (genvar i = 0; i < IN_FIELDS; i++) begin : g_fld
		assign fld[i] = $signed(s_axis_tdata[i*COORD_W +: COORD_W]);
	end

	// stage 1: differences about the apex
	logic signed [DIFF_W-1:0] ux_s1, uy_s1;
	side_t                    side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1        <= DIFF_W'(fld[8]) - DIFF_W'(fld[6]);
			uy_s1        <= DIFF_W'(fld[9]) - DIFF_W'(fld[7]);
			side_s1.vx   <= DIFF_W'(fld[4]) - DIFF_W'(fld[6]);
			side_s1.vy   <= DIFF_W'(fld[5]) - DIFF_W'(fld[7]);
			side_s1.wx   <= DIFF_W'(fld[2]) - DIFF_W'(fld[6]);
			side_s1.wy   <= DIFF_W'(fld[3]) - DIFF_W'(fld[7]);
			side_s1.fx   <= DIFF_W'(fld[6]) - DIFF_W'(fld[0]);
			side_s1.fy   <= DIFF_W'(fld[7]) - DIFF_W'(fld[1]);
			side_s1.d2x  <= fld[6];
			side_s1.d2y  <= fld[7];
		end
	end

	// unit directions of both legs
	logic signed [DIR_W-1:0] ca, sa, cb, sb;

	dpri_unit u_unit_u (
		.clk(clk), .en(en), .vec_x(ux_s1), .vec_y(uy_s1), .dir_x(ca), .dir_y(sa)
	);

	dpri_unit u_unit_v (
		.clk(clk), .en(en), .vec_x(side_s1.vx), .vec_y(side_s1.vy), .dir_x(cb), .dir_y(sb)
	);

	// side data waits alongside the direction units
	side_t dl_s [0:UNIT_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[0] <= side_s1;
			for (int i = 1; i < UNIT_LAT; i++) begin
				dl_s[i] <= dl_s[i-1];
			end
		end
	end

	// stage 2: dot and cross products of the directions
	logic signed [2*DIR_W-1:0] cc_s2, ss_s2, cs_s2, sc_s2;
	side_t                     side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s2   <= ca * cb;
			ss_s2   <= sa * sb;
			cs_s2   <= ca * sb;
			sc_s2   <= sa * cb;
			side_s2 <= dl_s[UNIT_LAT-1];
		end
	end

	// stage 3: rotation cosine and sine
	logic signed [CS_W-1:0] c_s3, s_s3;
	side_t                  side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3    <= CS_W'(rnd_q28(RND_IN_W'(cc_s2) + RND_IN_W'(ss_s2)));
			s_s3    <= CS_W'(rnd_q28(RND_IN_W'(cs_s2) - RND_IN_W'(sc_s2)));
			side_s3 <= side_s2;
		end
	end

	// stage 4: rotation products for B and the back-turned leg
	logic signed [CS_W+DIFF_W-1:0] cwx_s4, swy_s4, swx_s4, cwy_s4;
	logic signed [CS_W+DIFF_W-1:0] cvx_s4, svy_s4, svx_s4, cvy_s4;
	side_t                         side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cwx_s4  <= c_s3 * side_s3.wx;
			swy_s4  <= s_s3 * side_s3.wy;
			swx_s4  <= s_s3 * side_s3.wx;
			cwy_s4  <= c_s3 * side_s3.wy;
			cvx_s4  <= c_s3 * side_s3.vx;
			svy_s4  <= s_s3 * side_s3.vy;
			svx_s4  <= s_s3 * side_s3.vx;
			cvy_s4  <= c_s3 * side_s3.vy;
			side_s4 <= side_s3;
		end
	end

	// stage 5: direction A to rotated B, and leg turned back
	logic signed [E_W-1:0] ex_s5, ey_s5;
	logic signed [G_W-1:0] gx_s5, gy_s5;
	side_t                 side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s5   <= E_W'(side_s4.fx)
				+ E_W'(rnd_q28(RND_IN_W'(cwx_s4) - RND_IN_W'(swy_s4)));
			ey_s5   <= E_W'(side_s4.fy)
				+ E_W'(rnd_q28(RND_IN_W'(swx_s4) + RND_IN_W'(cwy_s4)));
			gx_s5   <= rnd_q28(RND_IN_W'(cvx_s4) + RND_IN_W'(svy_s4));
			gy_s5   <= rnd_q28(RND_IN_W'(cvy_s4) - RND_IN_W'(svx_s4));
			side_s5 <= side_s4;
		end
	end

	// stage 6: cross product terms
	logic signed [E_W+DIFF_W-1:0] exvy_s6, eyvx_s6, fxey_s6, fyex_s6;
	logic signed [G_W-1:0]        gx_s6, gy_s6;
	side_t                        side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			exvy_s6 <= ex_s5 * side_s5.vy;
			eyvx_s6 <= ey_s5 * side_s5.vx;
			fxey_s6 <= side_s5.fx * ey_s5;
			fyex_s6 <= side_s5.fy * ex_s5;
			gx_s6   <= gx_s5;
			gy_s6   <= gy_s5;
			side_s6 <= side_s5;
		end
	end

	// stage 7: denominator and numerator
	logic signed [P_W-1:0] den_s7, nm_s7;
	logic signed [G_W-1:0] gx_s7, gy_s7;
	side_t                 side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7  <= P_W'(exvy_s6) - P_W'(eyvx_s6);
			nm_s7   <= P_W'(fxey_s6) - P_W'(fyex_s6);
			gx_s7   <= gx_s6;
			gy_s7   <= gy_s6;
			side_s7 <= side_s6;
		end
	end

	// magnitudes and signs of the four quotients
	logic [P_W-1:0]    nm_mag, den_abs;
	logic [DIFF_W-1:0] vx_mag, vy_mag;
	logic [G_W-1:0]    gx_mag, gy_mag;
	logic              nm_neg, den_neg;

	always_comb begin
		nm_neg  = nm_s7[P_W-1];
		den_neg = den_s7[P_W-1];
		nm_mag  = nm_neg ? P_W'(-nm_s7) : P_W'(nm_s7);
		den_abs = den_neg ? P_W'(-den_s7) : P_W'(den_s7);
		vx_mag  = side_s7.vx[DIFF_W-1] ? DIFF_W'(-side_s7.vx) : DIFF_W'(side_s7.vx);
		vy_mag  = side_s7.vy[DIFF_W-1] ? DIFF_W'(-side_s7.vy) : DIFF_W'(side_s7.vy);
		gx_mag  = gx_s7[G_W-1] ? G_W'(-gx_s7) : G_W'(gx_s7);
		gy_mag  = gy_s7[G_W-1] ? G_W'(-gy_s7) : G_W'(gy_s7);
	end

	// quotient order: P1 x, P1 y, P2 x, P2 y from bit 0 up
	logic [3:0][G_W-1:0] op_mag;
	mctl_t               ctl;

	assign op_mag = {gy_mag, gx_mag, G_W'(vy_mag), G_W'(vx_mag)};
	assign ctl = '{
		neg: {nm_neg ^ gy_s7[G_W-1] ^ den_neg, nm_neg ^ gx_s7[G_W-1] ^ den_neg,
			nm_neg ^ side_s7.vy[DIFF_W-1] ^ den_neg,
			nm_neg ^ side_s7.vx[DIFF_W-1] ^ den_neg},
		den: DEN_W'(den_abs),
		par: (side_s7.vx == '0 && side_s7.vy == '0) || den_s7 == '0,
		d2x: side_s7.d2x,
		d2y: side_s7.d2y
	};

	// stages 8 to 11: numerator products, one numerator limb per stage
	logic [3:0][NUM_W-1:0] acc_s  [0:MUL_STEPS-1];
	logic [P_W-1:0]        mnm_s  [0:MUL_STEPS-2];
	logic [3:0][G_W-1:0]   mop_s  [0:MUL_STEPS-2];
	mctl_t                 mctl_s [0:MUL_STEPS-1];

	for (genvar k = 0; k < MUL_STEPS; k++) begin : g_mul
		logic [P_W-1:0]               nm_in;
		logic [3:0][G_W-1:0]          op_in;
		logic [3:0][NUM_W-1:0]        acc_in;
		mctl_t                        ctl_in;
		logic [MUL_LIMB-1:0]          limb;
		logic [3:0][MUL_LIMB+G_W-1:0] pp;

		if (k == 0) begin : g_first
			assign nm_in  = nm_mag;
			assign op_in  = op_mag;
			assign acc_in = '0;
			assign ctl_in = ctl;
		end else begin : g_next
			assign nm_in  = mnm_s[k-1];
			assign op_in  = mop_s[k-1];
			assign acc_in = acc_s[k-1];
			assign ctl_in = mctl_s[k-1];
		end

		assign limb = MUL_LIMB'(nm_in >> (k * MUL_LIMB));

		for (genvar j = 0; j < 4; j++) begin : g_pp
			assign pp[j] = limb * op_in[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 4; j++) begin
					acc_s[k][j] <= acc_in[j] + (NUM_W'(pp[j]) << (k * MUL_LIMB));
				end
				mctl_s[k] <= ctl_in;
			end
		end

		if (k < MUL_STEPS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					mnm_s[k] <= nm_in;
					mop_s[k] <= op_in;
				end
			end
		end
	end

	logic [3:0][NUM_W-1:0] prod;
	mctl_t                 ctl_m;

	assign prod  = acc_s[MUL_STEPS-1];
	assign ctl_m = mctl_s[MUL_STEPS-1];

	// dividers, their result registers form the output stage
	logic signed [COORD_W-1:0] p1x, p1y, p2x, p2y;

	dpri_div u_div_p1x (
		.clk(clk), .en(en), .num_mag(prod[0]), .num_neg(ctl_m.neg[0]), .den_mag(ctl_m.den),
		.base(ctl_m.d2x), .par(ctl_m.par), .res(p1x)
	);

	dpri_div u_div_p1y (
		.clk(clk), .en(en), .num_mag(prod[1]), .num_neg(ctl_m.neg[1]), .den_mag(ctl_m.den),
		.base(ctl_m.d2y), .par(ctl_m.par), .res(p1y)
	);

	dpri_div u_div_p2x (
		.clk(clk), .en(en), .num_mag(prod[2]), .num_neg(ctl_m.neg[2]), .den_mag(ctl_m.den),
		.base(ctl_m.d2x), .par(ctl_m.par), .res(p2x)
	);

	dpri_div u_div_p2y (
		.clk(clk), .en(en), .num_mag(prod[3]), .num_neg(ctl_m.neg[3]), .den_mag(ctl_m.den),
		.base(ctl_m.d2y), .par(ctl_m.par), .res(p2y)
	);

	// parallel flag follows the divider latency
	logic par_dl_s [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			par_dl_s[0] <= ctl_m.par;
			for (int i = 1; i < DIV_LAT; i++) begin
				par_dl_s[i] <= par_dl_s[i-1];
			end
		end
	end

	assign m_axis_tdata = {p2y, p2x, p1y, p1x};
	assign m_axis_tuser = par_dl_s[DIV_LAT-1];

endmodule
